FILE: rtl/assert_macros.svh
// Assertion macros shared by the queue and back-end RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while reset is released.
`define PAC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define PAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PAC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/pac_pkg.sv
// Types and constants of the proximity avoidance command block.
package pac_pkg;

  localparam int unsigned DistW  = 10;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned CfgAW  = 2;
  localparam int unsigned NumCls = 10;
  localparam int unsigned ClsW   = 4;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  localparam logic [DistW-1:0] MinDistRst = 10'd3;
  localparam logic [DistW-1:0] NearRst    = 10'd100;
  localparam logic [DistW-1:0] FarRst     = 10'd200;

  typedef enum logic [CfgAW-1:0] {
    CFG_MIN_DIST = 2'd0,
    CFG_NEAR     = 2'd1,
    CFG_FAR      = 2'd2
  } cfg_idx_e;

  // Command classes in ascending code order, so a scan from class 0 up
  // meets smaller codes first.
  typedef enum logic [ClsW-1:0] {
    CLS_BACK    = 4'd0,  // 'B' 66
    CLS_FWD     = 4'd1,  // 'F' 70
    CLS_LEFT    = 4'd2,  // 'L' 76
    CLS_RIGHT   = 4'd3,  // 'R' 82
    CLS_STOP    = 4'd4,  // 'S' 83
    CLS_HOLD    = 4'd5,  // 'X' 88
    CLS_BACK_S  = 4'd6,  // 'b' 98
    CLS_FWD_S   = 4'd7,  // 'f' 102
    CLS_LEFT_S  = 4'd8,  // 'l' 108
    CLS_RIGHT_S = 4'd9   // 'r' 114
  } cls_e;

  typedef enum logic [1:0] {
    BK_FILL = 2'd0,
    BK_SCAN = 2'd1,
    BK_EMIT = 2'd2
  } bk_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CodeW-1:0] cls_code(cls_e c);
    logic [CodeW-1:0] code;
    unique case (c)
      CLS_BACK:    code = 7'd66;
      CLS_FWD:     code = 7'd70;
      CLS_LEFT:    code = 7'd76;
      CLS_RIGHT:   code = 7'd82;
      CLS_STOP:    code = 7'd83;
      CLS_HOLD:    code = 7'd88;
      CLS_BACK_S:  code = 7'd98;
      CLS_FWD_S:   code = 7'd102;
      CLS_LEFT_S:  code = 7'd108;
      CLS_RIGHT_S: code = 7'd114;
      default:     code = 7'd88;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/pac_front.sv
// Front end: configuration registers, request intake and command classification.
module pac_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pac_pkg::CfgAW-1:0]   cfg_addr_i,
  input  logic [pac_pkg::DistW-1:0]   cfg_wdata_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [pac_pkg::DistW-1:0]   range_one_i,
  input  logic [pac_pkg::DistW-1:0]   range_two_i,
  input  logic [pac_pkg::DistW-1:0]   range_three_i,
  input  logic [pac_pkg::DistW-1:0]   range_four_i,
  input  logic [pac_pkg::DistW-1:0]   range_five_i,
  input  logic [pac_pkg::DistW-1:0]   range_six_i,
  input  pac_pkg::q_stat_t            q_stat_i,
  output logic                        q_push_o,
  output pac_pkg::cls_e               q_cls_o
);

  logic [pac_pkg::DistW-1:0] min_dist_q, near_q, far_q;
  logic [pac_pkg::DistW-1:0] rng [6];
  logic [5:0]                gt_min, lt_near, gt_near, lt_far, gt_far;
  logic                      v_q;
  pac_pkg::cls_e             cls_q, cls_d;
  logic                      accept;

  // Bit i of lt/gt is sensor i+1.
  function automatic pac_pkg::cls_e slide_tree(logic [5:0] lt, logic [5:0] gt);
    pac_pkg::cls_e res;
    if (lt[0]) begin
      res = gt[4] ? pac_pkg::CLS_LEFT : gt[2] ? pac_pkg::CLS_RIGHT :
            gt[3] ? pac_pkg::CLS_BACK_S : pac_pkg::CLS_STOP;
    end else if (lt[4]) begin
      res = gt[0] ? pac_pkg::CLS_FWD : gt[3] ? pac_pkg::CLS_BACK :
            gt[2] ? pac_pkg::CLS_RIGHT_S : pac_pkg::CLS_STOP;
    end else if (lt[2]) begin
      res = gt[0] ? pac_pkg::CLS_FWD : gt[3] ? pac_pkg::CLS_BACK :
            gt[4] ? pac_pkg::CLS_LEFT_S : pac_pkg::CLS_STOP;
    end else if (lt[1]) begin
      res = gt[4] ? pac_pkg::CLS_LEFT : gt[3] ? pac_pkg::CLS_BACK : pac_pkg::CLS_STOP;
    end else if (lt[5]) begin
      res = gt[2] ? pac_pkg::CLS_RIGHT : gt[3] ? pac_pkg::CLS_BACK : pac_pkg::CLS_STOP;
    end else if (lt[3]) begin
      res = gt[2] ? pac_pkg::CLS_RIGHT : gt[4] ? pac_pkg::CLS_LEFT :
            gt[0] ? pac_pkg::CLS_FWD_S : pac_pkg::CLS_STOP;
    end else begin
      res = pac_pkg::CLS_HOLD;
    end
    return res;
  endfunction

  function automatic pac_pkg::cls_e repulse_tree(logic [5:0] lt, logic [5:0] gt);
    pac_pkg::cls_e res;
    if (lt[0]) begin
      res = gt[3] ? pac_pkg::CLS_BACK : gt[2] ? pac_pkg::CLS_RIGHT :
            gt[4] ? pac_pkg::CLS_LEFT : pac_pkg::CLS_STOP;
    end else if (lt[4]) begin
      res = gt[2] ? pac_pkg::CLS_RIGHT : gt[3] ? pac_pkg::CLS_BACK :
            gt[0] ? pac_pkg::CLS_FWD : pac_pkg::CLS_STOP;
    end else if (lt[2]) begin
      res = gt[4] ? pac_pkg::CLS_LEFT : gt[3] ? pac_pkg::CLS_BACK :
            gt[0] ? pac_pkg::CLS_FWD : pac_pkg::CLS_STOP;
    end else if (lt[1]) begin
      res = gt[4] ? pac_pkg::CLS_LEFT : gt[3] ? pac_pkg::CLS_BACK : pac_pkg::CLS_STOP;
    end else if (lt[5]) begin
      res = gt[2] ? pac_pkg::CLS_RIGHT : gt[3] ? pac_pkg::CLS_BACK : pac_pkg::CLS_STOP;
    end else if (lt[3]) begin
      res = gt[0] ? pac_pkg::CLS_FWD : gt[4] ? pac_pkg::CLS_LEFT :
            gt[2] ? pac_pkg::CLS_RIGHT : pac_pkg::CLS_STOP;
    end else begin
      res = pac_pkg::CLS_HOLD;
    end
    return res;
  endfunction

  assign rng[0] = range_one_i;
  assign rng[1] = range_two_i;
  assign rng[2] = range_three_i;
  assign rng[3] = range_four_i;
  assign rng[4] = range_five_i;
  assign rng[5] = range_six_i;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      gt_min[i]  = rng[i] > min_dist_q;
      lt_near[i] = rng[i] < near_q;
      gt_near[i] = rng[i] > near_q;
      lt_far[i]  = rng[i] < far_q;
      gt_far[i]  = rng[i] > far_q;
    end
    if (&gt_near) begin
      cls_d = slide_tree(lt_far, gt_far);
    end else if (&gt_min) begin
      cls_d = repulse_tree(lt_near, gt_near);
    end else begin
      cls_d = pac_pkg::CLS_HOLD;
    end
  end

  assign q_push_o = v_q && !q_stat_i.full;
  assign full_o   = v_q && q_stat_i.full;
  assign accept   = push_i && !full_o;
  assign q_cls_o  = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= pac_pkg::MinDistRst;
      near_q     <= pac_pkg::NearRst;
      far_q      <= pac_pkg::FarRst;
    end else if (cfg_we_i) begin
      unique case (pac_pkg::cfg_idx_e'(cfg_addr_i))
        pac_pkg::CFG_MIN_DIST: min_dist_q <= cfg_wdata_i;
        pac_pkg::CFG_NEAR:     near_q     <= cfg_wdata_i;
        pac_pkg::CFG_FAR:      far_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (accept) begin
      v_q <= 1'b1;
    end else if (q_push_o) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

endmodule

FILE: rtl/pac_queue.sv
// Short queue of command classes between front and back ends.
`include "assert_macros.svh"

module pac_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pac_pkg::cls_e     cls_i,
  input  logic              pop_i,
  output pac_pkg::cls_e     cls_o,
  output pac_pkg::q_stat_t  stat_o
);

  pac_pkg::cls_e                 mem_q [pac_pkg::QDepth];
  logic [pac_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [pac_pkg::QCntW-1:0]     cnt_q;
  logic                          do_push, do_pop;

  assign stat_o.full  = cnt_q == pac_pkg::QCntW'(pac_pkg::QDepth);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cls_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cls_i;
    end
  end

  `PAC_ASSERT(a_q_cnt_bound, clk_i, rst_ni, cnt_q <= pac_pkg::QCntW'(pac_pkg::QDepth), "queue count over depth")
  `PAC_ASSERT(a_q_no_overflow, clk_i, rst_ni, !(push_i && stat_o.full), "push into full queue")
  `PAC_ASSERT(a_q_ptr_gap, clk_i, rst_ni, (cnt_q == '0 || cnt_q == pac_pkg::QCntW'(pac_pkg::QDepth)) |-> wr_q == rd_q, "queue pointers disagree with count")

endmodule

FILE: rtl/pac_back.sv
// Back end: per-class window counts, mode scan and result register.
`include "assert_macros.svh"

module pac_back #(
  parameter int unsigned Window = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pac_pkg::q_stat_t           q_stat_i,
  input  pac_pkg::cls_e              q_cls_i,
  output logic                       q_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [pac_pkg::CodeW-1:0]  steer_code_o
);

  localparam int unsigned CntW = $clog2(Window + 1);

  pac_pkg::bk_state_e          state_q, state_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             cnt_q [pac_pkg::NumCls];
  logic [pac_pkg::ClsW-1:0]    scan_q, scan_d;
  logic [CntW-1:0]             best_cnt_q, best_cnt_d;
  pac_pkg::cls_e               best_cls_q, best_cls_d;
  logic [CntW-1:0]             cur_cnt;
  logic                        scanning, load_out;
  logic                        out_v_q;
  logic [pac_pkg::CodeW-1:0]   out_code_q;

  assign cur_cnt  = cnt_q[scan_q];
  assign scanning = state_q == pac_pkg::BK_SCAN;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    scan_d     = scan_q;
    best_cnt_d = best_cnt_q;
    best_cls_d = best_cls_q;
    q_pop_o    = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      pac_pkg::BK_FILL: begin
        q_pop_o = !q_stat_i.empty;
        if (q_pop_o) begin
          if (fill_q == CntW'(Window - 1)) begin
            fill_d     = '0;
            scan_d     = '0;
            best_cnt_d = '0;
            best_cls_d = pac_pkg::CLS_BACK;
            state_d    = pac_pkg::BK_SCAN;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      pac_pkg::BK_SCAN: begin
        if (cur_cnt > best_cnt_q) begin
          best_cnt_d = cur_cnt;
          best_cls_d = pac_pkg::cls_e'(scan_q);
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == pac_pkg::ClsW'(pac_pkg::NumCls - 1)) begin
          state_d = pac_pkg::BK_EMIT;
        end
      end
      pac_pkg::BK_EMIT: begin
        if (!out_v_q || pop_i) begin
          load_out = 1'b1;
          state_d  = pac_pkg::BK_FILL;
        end
      end
      default: state_d = pac_pkg::BK_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pac_pkg::BK_FILL;
      fill_q  <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_cnt_q <= best_cnt_d;
    best_cls_q <= best_cls_d;
  end

  // Each count is cleared as the scan passes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pac_pkg::NumCls; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < pac_pkg::NumCls; k++) begin
        if (q_pop_o && q_cls_i == pac_pkg::cls_e'(k)) begin
          cnt_q[k] <= cnt_q[k] + 1'b1;
        end else if (scanning && scan_q == pac_pkg::ClsW'(k)) begin
          cnt_q[k] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (pop_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_code_q <= pac_pkg::cls_code(best_cls_q);
    end
  end

  assign empty_o      = !out_v_q;
  assign steer_code_o = out_code_q;

  `PAC_ASSERT(a_bk_fill_bound, clk_i, rst_ni, fill_q < CntW'(Window), "fill count reached window size")
  `PAC_ASSERT(a_bk_scan_bound, clk_i, rst_ni, scanning |-> scan_q < pac_pkg::ClsW'(pac_pkg::NumCls), "scan index past last class")
  `PAC_ASSERT(a_bk_no_pop_busy, clk_i, rst_ni, (state_q != pac_pkg::BK_FILL) |-> !q_pop_o, "queue popped while scanning")

endmodule

FILE: rtl/proximity_avoidance_command.sv
// Top level of the proximity avoidance command block.
// Usage:
//   Input queue side: drive the six range readings (cm) and raise push; a
//   request is taken at a clock edge with push high and full low.
//   Result side: while empty is low, steer_code_o holds the oldest result;
//   it is taken at an edge with pop high. One result per WINDOW requests.
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_addr_i (0 min
//   distance, 1 near threshold, 2 far threshold); other indexes are ignored.
// Flow:
//   Requests are taken one per cycle while full is low. The back end pops
//   one request per cycle while the queue is not empty and it fills a
//   window, then scans the command classes and has one load step per
//   window; it pops nothing during the scan and load. The last request of
//   a window passes the front register, the queue, the scan and the load step.
// Reset: thresholds return to 3/100/200, the window and queues empty.
// A stalled result holds the scan in its load step; the 4-entry queue and
// the front register keep taking requests until they fill, then full rises.
module proximity_avoidance_command #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pac_pkg::CfgAW-1:0]   cfg_addr_i,
  input  logic [pac_pkg::DistW-1:0]   cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [pac_pkg::DistW-1:0]   range_one_i,
  input  logic [pac_pkg::DistW-1:0]   range_two_i,
  input  logic [pac_pkg::DistW-1:0]   range_three_i,
  input  logic [pac_pkg::DistW-1:0]   range_four_i,
  input  logic [pac_pkg::DistW-1:0]   range_five_i,
  input  logic [pac_pkg::DistW-1:0]   range_six_i,
  input  logic                        pop,
  output logic                        empty,
  output logic [pac_pkg::CodeW-1:0]   steer_code_o
);

  pac_pkg::q_stat_t q_stat;
  logic             q_push, q_pop;
  pac_pkg::cls_e    q_in_cls, q_out_cls;

  pac_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .full_o        (full),
    .range_one_i   (range_one_i),
    .range_two_i   (range_two_i),
    .range_three_i (range_three_i),
    .range_four_i  (range_four_i),
    .range_five_i  (range_five_i),
    .range_six_i   (range_six_i),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_cls_o       (q_in_cls)
  );

  pac_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cls_i  (q_in_cls),
    .pop_i  (q_pop),
    .cls_o  (q_out_cls),
    .stat_o (q_stat)
  );

  pac_back #(
    .Window (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .q_cls_i      (q_out_cls),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .steer_code_o (steer_code_o)
  );

endmodule
